// ----- src/tgo_pkg.sv -----
// Shared types and constants for the tone generator with one-shot unit.
`timescale 1ns / 1ps

package tgo_pkg;

   localparam int FREQ_W = 16;   // frequency register width
   localparam int DUR_W  = 16;   // duration register width
   localparam int HALF_W = 16;   // half period / elapsed counter width
   localparam int NUM_SOUNDS = 3;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_CMD  = 1'b1;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_FREQ_WARN_ONE = 3'd0;
   localparam logic [2:0] REG_FREQ_WARN_TWO = 3'd1;
   localparam logic [2:0] REG_FREQ_TRACK    = 3'd2;
   localparam logic [2:0] REG_DUR_WARN_ONE  = 3'd3;
   localparam logic [2:0] REG_DUR_WARN_TWO  = 3'd4;
   localparam logic [2:0] REG_DUR_TRACK     = 3'd5;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_CONT    = 2'd1,
      MODE_ONESHOT = 2'd2,
      MODE_NONE    = 2'd3   // nothing applied yet; also an invalid request
   } mode_type;

   typedef enum logic [1:0] {
      SOUND_WARN_ONE = 2'd0,
      SOUND_WARN_TWO = 2'd1,
      SOUND_TRACK    = 2'd2,
      SOUND_SILENT   = 2'd3
   } sound_type;

   typedef enum logic {
      ST_IDLE,
      ST_DIV
   } ctrl_state_type;

   typedef struct packed {
      logic [NUM_SOUNDS-1:0][FREQ_W-1:0] freq;
      logic [NUM_SOUNDS-1:0][DUR_W-1:0]  dur;
   } cfg_type;

   typedef struct packed {
      logic apply;      // request accepted this cycle
      logic div_load;   // start the half-period division
      logic div_step;   // one quotient bit
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_tone; // accepted request starts a tone
      logic div_last;   // division finishes this cycle
   } dp_status_type;

endpackage

// ----- src/tone_generator_with_oneshot_unit.sv -----
// Top level of the square-wave tone generator with one-shot mode.
//
// Requests arrive on the req_ stream: tuser carries the opcode (0 tick,
// 1 command), tdata the requested mode and sound. Every request yields one
// result on the rsp_ stream with the speaker level, current mode and the
// one-shot busy flag after that request.
// The result is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the receiver takes each result,
// except for a command that starts a tone; it holds req_tready low while
// the bit-serial divider computes the half period round(TICK_RATE_HZ / 2f).
// The tone state registers serve as the result register: while a result
// waits on a stalled receiver, the next request is accepted in the cycle
// the receiver takes it, never earlier.
// Reset clears all tone state to off and the six frequency/duration
// registers to their defaults; no result is pending after reset.
// The user writes registers over csr_ only while no request is in progress; the block does not enforce this.
`timescale 1ns / 1ps

module tone_generator_with_oneshot_unit
   import tgo_pkg::*;
#(
   parameter int TICK_RATE_HZ = 1000
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [1:0] mode_req, [3:2] sound_req, [7:4] zero
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] speaker_level, [2:1] active_mode,
                                    // [3] oneshot_busy, [7:4] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg;
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          speaker_level;
   logic [1:0]    active_mode;
   logic          oneshot_busy;

   tgo_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tgo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tgo_dp #(
      .TICK_RATE_HZ (TICK_RATE_HZ)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .req_opcode    (req_tuser),
      .req_mode      (req_tdata[1:0]),
      .req_sound     (req_tdata[3:2]),
      .cmd           (cmd),
      .status        (status),
      .speaker_level (speaker_level),
      .active_mode   (active_mode),
      .oneshot_busy  (oneshot_busy)
   );

   assign rsp_tdata = {4'd0, oneshot_busy, active_mode, speaker_level};

endmodule

// ----- src/tgo_csr.sv -----
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module tgo_csr
   import tgo_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [FREQ_W-1:0] freq_ff [NUM_SOUNDS];
   logic [DUR_W-1:0]  dur_ff  [NUM_SOUNDS];
   logic [2:0]        index;
   logic              wr_en;
   logic [15:0]       rd_val;

   assign csr_pready = 1'b1;
   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff[0] <= 16'd2000;
         freq_ff[1] <= 16'd1000;
         freq_ff[2] <= 16'd440;
         dur_ff[0]  <= 16'd200;
         dur_ff[1]  <= 16'd200;
         dur_ff[2]  <= 16'd100;
      end else if (wr_en) begin
         case (index)
            REG_FREQ_WARN_ONE: freq_ff[0] <= csr_pwdata[FREQ_W-1:0];
            REG_FREQ_WARN_TWO: freq_ff[1] <= csr_pwdata[FREQ_W-1:0];
            REG_FREQ_TRACK:    freq_ff[2] <= csr_pwdata[FREQ_W-1:0];
            REG_DUR_WARN_ONE:  dur_ff[0]  <= csr_pwdata[DUR_W-1:0];
            REG_DUR_WARN_TWO:  dur_ff[1]  <= csr_pwdata[DUR_W-1:0];
            REG_DUR_TRACK:     dur_ff[2]  <= csr_pwdata[DUR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_FREQ_WARN_ONE: rd_val = freq_ff[0];
         REG_FREQ_WARN_TWO: rd_val = freq_ff[1];
         REG_FREQ_TRACK:    rd_val = freq_ff[2];
         REG_DUR_WARN_ONE:  rd_val = dur_ff[0];
         REG_DUR_WARN_TWO:  rd_val = dur_ff[1];
         REG_DUR_TRACK:     rd_val = dur_ff[2];
         default:           rd_val = 16'd0;
      endcase
   end

   assign csr_prdata = {16'd0, rd_val};

   always_comb begin
      for (int i = 0; i < NUM_SOUNDS; i++) begin
         cfg.freq[i] = freq_ff[i];
         cfg.dur[i]  = dur_ff[i];
      end
   end

endmodule

// ----- src/tgo_ctrl.sv -----
// Controller: request handshake, result valid and the division sequencer.
`timescale 1ns / 1ps

module tgo_ctrl
   import tgo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;

   // Datapath state doubles as the result register, so a new request is
   // taken only once the pending result leaves.
   assign req_tready = (state_ff == ST_IDLE) & (~rsp_valid_ff | rsp_tready);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && status.start_tone) state_in = ST_DIV;
         ST_DIV:  if (status.div_last) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.apply    = accept;
            cmd.div_load = accept & status.start_tone;
         end
         ST_DIV:  cmd.div_step = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_comb begin
      if (accept) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/tgo_dp.sv -----
// Datapath: tone state, waveform counters and the half-period divider.
`timescale 1ns / 1ps

module tgo_dp
   import tgo_pkg::*;
#(
   parameter int TICK_RATE_HZ = 1000
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_opcode,
   input  logic [1:0]    req_mode,
   input  logic [1:0]    req_sound,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   output logic          speaker_level,
   output logic [1:0]    active_mode,
   output logic          oneshot_busy
);

   // (rate + f) needs this many bits; quotient bits come one per cycle
   localparam int NUM_W = $clog2(TICK_RATE_HZ + (1 << FREQ_W));
   localparam int CNT_W = $clog2(NUM_W + 1);

   mode_type          mode_ff, mode_in;
   sound_type         sound_ff, sound_in;
   mode_type          app_mode_ff, app_mode_in;
   sound_type         app_sound_ff, app_sound_in;
   logic              tone_en_ff, tone_en_in;
   logic [HALF_W-1:0] half_ff, half_in;
   logic [HALF_W-1:0] elapsed_ff, elapsed_in;
   logic [DUR_W-1:0]  remain_ff, remain_in;
   logic              pin_ff, pin_in;

   logic [NUM_W-1:0]  div_num_ff, div_num_in;
   logic [NUM_W-1:0]  div_den_ff, div_den_in;
   logic [NUM_W-1:0]  div_rem_ff, div_rem_in;
   logic [NUM_W-1:0]  div_quo_ff, div_quo_in;
   logic [CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [NUM_W:0]    rem_sh;
   logic              q_bit;

   mode_type          m_req;
   sound_type         s_req;
   logic [FREQ_W-1:0] f_sel;
   logic [DUR_W-1:0]  d_sel;
   logic              start;
   logic [HALF_W-1:0] e_inc;

   assign m_req = mode_type'(req_mode);
   assign s_req = sound_type'(req_sound);

   always_comb begin
      case (s_req)
         SOUND_WARN_ONE: begin f_sel = cfg.freq[0]; d_sel = cfg.dur[0]; end
         SOUND_WARN_TWO: begin f_sel = cfg.freq[1]; d_sel = cfg.dur[1]; end
         SOUND_TRACK:    begin f_sel = cfg.freq[2]; d_sel = cfg.dur[2]; end
         default:        begin f_sel = '0;          d_sel = '0;          end
      endcase
   end

   assign e_inc = elapsed_ff + HALF_W'(1);

   // Next tone state for the request at the port; committed on cmd.apply.
   always_comb begin
      mode_in      = mode_ff;
      sound_in     = sound_ff;
      app_mode_in  = app_mode_ff;
      app_sound_in = app_sound_ff;
      tone_en_in   = tone_en_ff;
      elapsed_in   = elapsed_ff;
      remain_in    = remain_ff;
      pin_in       = pin_ff;
      start        = 1'b0;

      if (req_opcode == OP_CMD) begin
         if (mode_ff != MODE_ONESHOT && m_req != MODE_NONE) begin
            mode_in  = m_req;
            sound_in = s_req;
            case (m_req)
               MODE_OFF: begin
                  if (app_mode_ff != MODE_OFF) begin
                     tone_en_in = 1'b0;
                     elapsed_in = '0;
                     pin_in     = 1'b0;
                  end
                  app_mode_in  = MODE_OFF;
                  app_sound_in = s_req;
               end
               MODE_CONT: begin
                  if (app_mode_ff != MODE_CONT || app_sound_ff != s_req) begin
                     start        = (f_sel != '0);
                     tone_en_in   = (f_sel != '0);
                     elapsed_in   = '0;
                     pin_in       = 1'b0;
                     app_mode_in  = MODE_CONT;
                     app_sound_in = s_req;
                  end
               end
               MODE_ONESHOT: begin
                  elapsed_in   = '0;
                  pin_in       = 1'b0;
                  app_sound_in = s_req;
                  if (f_sel != '0 && d_sel != '0) begin
                     start       = 1'b1;
                     tone_en_in  = 1'b1;
                     remain_in   = d_sel;
                     app_mode_in = MODE_ONESHOT;
                  end else begin
                     // nothing to play: straight back to off
                     tone_en_in  = 1'b0;
                     remain_in   = '0;
                     mode_in     = MODE_OFF;
                     app_mode_in = MODE_OFF;
                  end
               end
               default: ;
            endcase
         end
      end else begin
         if (mode_ff == MODE_ONESHOT && remain_ff <= DUR_W'(1)) begin
            tone_en_in   = 1'b0;
            elapsed_in   = '0;
            pin_in       = 1'b0;
            remain_in    = '0;
            mode_in      = MODE_OFF;
            app_mode_in  = MODE_OFF;
            app_sound_in = sound_ff;
         end else if (mode_ff == MODE_CONT || mode_ff == MODE_ONESHOT) begin
            if (mode_ff == MODE_ONESHOT) remain_in = remain_ff - DUR_W'(1);
            if (tone_en_ff && half_ff != '0) begin
               if (e_inc >= half_ff) begin
                  pin_in     = ~pin_ff;
                  elapsed_in = e_inc - half_ff;
               end else begin
                  elapsed_in = e_inc;
               end
            end
         end
      end
   end

   assign status.start_tone = start;
   assign status.div_last   = (div_cnt_ff == CNT_W'(NUM_W - 1));

   // Restoring divider: (rate + f) / (2 f), one quotient bit per cycle
   assign rem_sh = {div_rem_ff, div_num_ff[NUM_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, div_den_ff});

   always_comb begin
      div_num_in = div_num_ff;
      div_den_in = div_den_ff;
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_cnt_in = div_cnt_ff;
      half_in    = half_ff;
      if (cmd.div_load) begin
         div_num_in = NUM_W'(TICK_RATE_HZ) + NUM_W'(f_sel);
         div_den_in = NUM_W'({f_sel, 1'b0});
         div_rem_in = '0;
         div_quo_in = '0;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         div_num_in = {div_num_ff[NUM_W-2:0], 1'b0};
         div_rem_in = q_bit ? NUM_W'(rem_sh - {1'b0, div_den_ff})
                            : rem_sh[NUM_W-1:0];
         div_quo_in = {div_quo_ff[NUM_W-2:0], q_bit};
         div_cnt_in = div_cnt_ff + CNT_W'(1);
         if (status.div_last) begin
            // clamp to at least one tick
            half_in = (div_quo_in == '0) ? HALF_W'(1) : div_quo_in[HALF_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         sound_ff     <= SOUND_WARN_ONE;
         app_mode_ff  <= MODE_NONE;
         app_sound_ff <= SOUND_SILENT;
         tone_en_ff   <= 1'b0;
         half_ff      <= '0;
         elapsed_ff   <= '0;
         remain_ff    <= '0;
         pin_ff       <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         if (cmd.apply) begin
            mode_ff      <= mode_in;
            sound_ff     <= sound_in;
            app_mode_ff  <= app_mode_in;
            app_sound_ff <= app_sound_in;
            tone_en_ff   <= tone_en_in;
            elapsed_ff   <= elapsed_in;
            remain_ff    <= remain_in;
            pin_ff       <= pin_in;
         end
         half_ff    <= half_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_num_ff <= div_num_in;
      div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
   end

   assign speaker_level = pin_ff;
   assign active_mode   = mode_ff;
   assign oneshot_busy  = (mode_ff == MODE_ONESHOT);

endmodule
